@@ hw/rtl/a2b_pkg.sv @@
package a2b_pkg;

	localparam logic [7:0] TABLE_SIZE = 8'd91;
	localparam logic [4:0] CODE_FIGS  = 5'd27;
	localparam logic [4:0] CODE_LTRS  = 5'd31;

	typedef enum logic [1:0] {
		SH_UNKNOWN = 2'd0,
		SH_LTRS    = 2'd1,
		SH_FIGS    = 2'd2
	} shift_t;

	typedef struct packed {
		logic       figs;
		logic [4:0] code;
	} entry_t;

	// Decision for one character, handed from the decoder to the output logic.
	typedef struct packed {
		logic       drop;
		logic       emit_shift;
		logic [4:0] shift_code;
		logic [4:0] char_code;
		shift_t     next_shift;
	} decode_t;

	function automatic entry_t lookup(input logic [6:0] idx);
		entry_t e;
		e = '{figs: 1'b0, code: 5'd0};
		case (idx)
			7'h07: e = '{figs: 1'b1, code: 5'd11};
			7'h0A: e = '{figs: 1'b0, code: 5'd2};
			7'h0D: e = '{figs: 1'b0, code: 5'd8};
			7'h20: e = '{figs: 1'b0, code: 5'd4};
			7'h21: e = '{figs: 1'b1, code: 5'd13};
			7'h22: e = '{figs: 1'b1, code: 5'd17};
			7'h23: e = '{figs: 1'b1, code: 5'd20};
			7'h24: e = '{figs: 1'b1, code: 5'd9};
			7'h26: e = '{figs: 1'b1, code: 5'd26};
			7'h28: e = '{figs: 1'b1, code: 5'd15};
			7'h29: e = '{figs: 1'b1, code: 5'd18};
			7'h2B: e = '{figs: 1'b1, code: 5'd17};
			7'h2C: e = '{figs: 1'b1, code: 5'd12};
			7'h2D: e = '{figs: 1'b1, code: 5'd3};
			7'h2E: e = '{figs: 1'b1, code: 5'd28};
			7'h2F: e = '{figs: 1'b1, code: 5'd29};
			7'h30: e = '{figs: 1'b1, code: 5'd22};
			7'h31: e = '{figs: 1'b1, code: 5'd23};
			7'h32: e = '{figs: 1'b1, code: 5'd19};
			7'h33: e = '{figs: 1'b1, code: 5'd1};
			7'h34: e = '{figs: 1'b1, code: 5'd10};
			7'h35: e = '{figs: 1'b1, code: 5'd16};
			7'h36: e = '{figs: 1'b1, code: 5'd21};
			7'h37: e = '{figs: 1'b1, code: 5'd7};
			7'h38: e = '{figs: 1'b1, code: 5'd6};
			7'h39: e = '{figs: 1'b1, code: 5'd24};
			7'h3A: e = '{figs: 1'b1, code: 5'd14};
			7'h3B: e = '{figs: 1'b1, code: 5'd30};
			7'h3F: e = '{figs: 1'b1, code: 5'd25};
			7'h41: e = '{figs: 1'b0, code: 5'd3};
			7'h42: e = '{figs: 1'b0, code: 5'd25};
			7'h43: e = '{figs: 1'b0, code: 5'd14};
			7'h44: e = '{figs: 1'b0, code: 5'd9};
			7'h45: e = '{figs: 1'b0, code: 5'd1};
			7'h46: e = '{figs: 1'b0, code: 5'd13};
			7'h47: e = '{figs: 1'b0, code: 5'd26};
			7'h48: e = '{figs: 1'b0, code: 5'd20};
			7'h49: e = '{figs: 1'b0, code: 5'd6};
			7'h4A: e = '{figs: 1'b0, code: 5'd11};
			7'h4B: e = '{figs: 1'b0, code: 5'd15};
			7'h4C: e = '{figs: 1'b0, code: 5'd18};
			7'h4D: e = '{figs: 1'b0, code: 5'd28};
			7'h4E: e = '{figs: 1'b0, code: 5'd12};
			7'h4F: e = '{figs: 1'b0, code: 5'd24};
			7'h50: e = '{figs: 1'b0, code: 5'd22};
			7'h51: e = '{figs: 1'b0, code: 5'd23};
			7'h52: e = '{figs: 1'b0, code: 5'd10};
			7'h53: e = '{figs: 1'b0, code: 5'd5};
			7'h54: e = '{figs: 1'b0, code: 5'd16};
			7'h55: e = '{figs: 1'b0, code: 5'd7};
			7'h56: e = '{figs: 1'b0, code: 5'd30};
			7'h57: e = '{figs: 1'b0, code: 5'd19};
			7'h58: e = '{figs: 1'b0, code: 5'd29};
			7'h59: e = '{figs: 1'b0, code: 5'd21};
			7'h5A: e = '{figs: 1'b0, code: 5'd17};
			default: e = '{figs: 1'b0, code: 5'd0};
		endcase
		return e;
	endfunction

endpackage

@@ hw/rtl/ascii_to_baudot_encoder_core.sv @@
// Channel  Direction  Payload
// s_axis   in         tdata[7:0] = char_in, tuser[0] = start_of_message
// m_axis   out        tdata[4:0] = baudot_out (upper bits zero), tlast = last_of_run
//
// A character that needs no shift change gives one word; one that inserts a
// FIGS or LTRS word gives the shift word first and then the character word.
// The first output word passes through the input register and then the output register.
// Reset clears the valid flags and sets the shift to unknown.
// While the output stalls or a character word is pending, a full input register holds and s_axis_tready drops.
module ascii_to_baudot_encoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] char_in
	input  logic       s_axis_tuser,   // [0] start_of_message
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [4:0] baudot_out, [7:5] zero
	output logic       m_axis_tlast    // last_of_run
);

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             som_s1;
	a2b_pkg::shift_t  shift_q;
	a2b_pkg::decode_t dec;

	logic             out_valid_q;
	logic [4:0]       out_code_q;
	logic             out_last_q;
	logic             pend_valid_q;
	logic [4:0]       pend_code_q;

	logic             out_free;
	logic             advance;

	a2b_decode u_decode (
		.char_in          (char_s1),
		.start_of_message (som_s1),
		.shift_cur        (shift_q),
		.dec              (dec)
	);

	assign out_free      = !out_valid_q || m_axis_tready;
	// The held character word must go out before a new input word is decoded.
	assign advance       = out_free && !pend_valid_q;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			som_s1  <= s_axis_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q      <= a2b_pkg::SH_UNKNOWN;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (out_free) begin
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (valid_s1) begin
				shift_q      <= dec.next_shift;
				out_valid_q  <= !dec.drop;
				pend_valid_q <= dec.emit_shift;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_valid_q) begin
				out_code_q <= pend_code_q;
				out_last_q <= 1'b1;
			end else if (valid_s1) begin
				out_code_q  <= dec.emit_shift ? dec.shift_code : dec.char_code;
				out_last_q  <= !dec.emit_shift;
				pend_code_q <= dec.char_code;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_code_q};
	assign m_axis_tlast  = out_last_q;

endmodule

@@ hw/rtl/a2b_decode.sv @@
module a2b_decode (
	input  logic [7:0]       char_in,
	input  logic             start_of_message,
	input  a2b_pkg::shift_t  shift_cur,
	output a2b_pkg::decode_t dec
);

	a2b_pkg::entry_t entry;
	a2b_pkg::shift_t base_shift;
	a2b_pkg::shift_t need;
	logic            in_range;

	assign in_range = char_in < a2b_pkg::TABLE_SIZE;
	assign entry    = a2b_pkg::lookup(char_in[6:0]);
	assign need     = entry.figs ? a2b_pkg::SH_FIGS : a2b_pkg::SH_LTRS;

	// A start flag forgets the shift even when the byte itself is dropped.
	assign base_shift = start_of_message ? a2b_pkg::SH_UNKNOWN : shift_cur;

	always_comb begin
		dec.drop       = !in_range || (entry.code == 5'd0);
		dec.emit_shift = !dec.drop && (base_shift != need);
		dec.shift_code = entry.figs ? a2b_pkg::CODE_FIGS : a2b_pkg::CODE_LTRS;
		dec.char_code  = entry.code;
		dec.next_shift = dec.drop ? base_shift : need;
	end

endmodule
